/* rtl/mck_pkg.sv */
// Shared types, constants and the Morse pattern table of the keyer.
package mck_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned UnitW      = 10;
  localparam int unsigned DurW       = 12;
  localparam int unsigned LenW       = 3;
  localparam int unsigned ElemW      = 5;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned JobDepth   = 4;

  localparam logic [UnitW-1:0] UnitReset = 10'd200;
  localparam logic [UnitW-1:0] UnitMin   = 10'd1;
  localparam logic [UnitW-1:0] UnitMax   = 10'd1000;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] CaseFold = 8'h20;
  localparam logic [SlotW-1:0] DigitBase = 6'd26;

  typedef enum logic {
    JOB_SPACE,
    JOB_LETTER
  } job_kind_e;

  // Elements are left aligned: the first element sits in the top bit, 1 is a dash.
  typedef struct packed {
    job_kind_e        kind;
    logic [LenW-1:0]  len;
    logic [ElemW-1:0] elems;
  } job_t;

  // Pattern code: element count in bits 7..5, elements right aligned in 4..0.
  function automatic logic [7:0] morse_pattern(input logic [SlotW-1:0] slot);
    logic [7:0] p;
    case (slot)
      6'd0:  p = {3'd2, 5'd1};
      6'd1:  p = {3'd4, 5'd8};
      6'd2:  p = {3'd4, 5'd10};
      6'd3:  p = {3'd3, 5'd4};
      6'd4:  p = {3'd1, 5'd0};
      6'd5:  p = {3'd4, 5'd2};
      6'd6:  p = {3'd3, 5'd6};
      6'd7:  p = {3'd4, 5'd0};
      6'd8:  p = {3'd2, 5'd0};
      6'd9:  p = {3'd4, 5'd7};
      6'd10: p = {3'd3, 5'd5};
      6'd11: p = {3'd4, 5'd4};
      6'd12: p = {3'd2, 5'd3};
      6'd13: p = {3'd2, 5'd2};
      6'd14: p = {3'd3, 5'd7};
      6'd15: p = {3'd4, 5'd6};
      6'd16: p = {3'd4, 5'd13};
      6'd17: p = {3'd3, 5'd2};
      6'd18: p = {3'd3, 5'd0};
      6'd19: p = {3'd1, 5'd1};
      6'd20: p = {3'd3, 5'd1};
      6'd21: p = {3'd4, 5'd1};
      6'd22: p = {3'd3, 5'd3};
      6'd23: p = {3'd4, 5'd9};
      6'd24: p = {3'd4, 5'd11};
      6'd25: p = {3'd4, 5'd12};
      6'd26: p = {3'd5, 5'd31};
      6'd27: p = {3'd5, 5'd15};
      6'd28: p = {3'd5, 5'd7};
      6'd29: p = {3'd5, 5'd3};
      6'd30: p = {3'd5, 5'd1};
      6'd31: p = {3'd5, 5'd0};
      6'd32: p = {3'd5, 5'd16};
      6'd33: p = {3'd5, 5'd24};
      6'd34: p = {3'd5, 5'd28};
      6'd35: p = {3'd5, 5'd30};
      default: p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/mck_front.sv */
// Front end: folds case, classifies a character and builds its keying job.
module mck_front (
  input  logic [mck_pkg::CharW-1:0] char_code_i,
  output logic                      job_valid_o,
  output mck_pkg::job_t             job_o
);

  logic [mck_pkg::CharW-1:0] ch;
  logic [mck_pkg::SlotW-1:0] slot;
  logic [7:0]                pat;
  logic [mck_pkg::LenW-1:0]  len;
  logic                      is_alpha;
  logic                      is_digit;

  always_comb begin
    ch = char_code_i;
    if (char_code_i >= mck_pkg::ChLowerA && char_code_i <= mck_pkg::ChLowerZ) begin
      ch = char_code_i - mck_pkg::CaseFold;
    end
    is_alpha = (ch >= mck_pkg::ChUpperA) && (ch <= mck_pkg::ChUpperZ);
    is_digit = (ch >= mck_pkg::ChZero) && (ch <= mck_pkg::ChNine);
    if (is_alpha) begin
      slot = mck_pkg::SlotW'(ch - mck_pkg::ChUpperA);
    end else begin
      slot = mck_pkg::DigitBase + mck_pkg::SlotW'(ch - mck_pkg::ChZero);
    end
    pat = mck_pkg::morse_pattern(slot);
    len = pat[7:5];

    job_valid_o = is_alpha || is_digit || (ch == mck_pkg::ChSpace);
    job_o.kind  = (ch == mck_pkg::ChSpace) ? mck_pkg::JOB_SPACE : mck_pkg::JOB_LETTER;
    job_o.len   = len;
    // Left align the elements so the back end always reads the top bit.
    job_o.elems = pat[4:0] << (3'(mck_pkg::ElemW) - len);
  end

endmodule

/* rtl/mck_job_fifo.sv */
// Small job queue between the front end and the sequencer.
module mck_job_fifo #(
  parameter int unsigned Depth = mck_pkg::JobDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  mck_pkg::job_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          empty_o,
  output mck_pkg::job_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mck_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/mck_back.sv */
// Back end: steps through one job and emits its intervals into the output register.
module mck_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mck_pkg::UnitW-1:0] dot_time_i,
  input  logic                      job_empty_i,
  input  mck_pkg::job_t             job_i,
  output logic                      job_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic                      led_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ms_o,
  output logic                      last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_DARK,
    ST_CLOSE
  } state_e;

  state_e                    state_q;
  mck_pkg::job_kind_e        kind_q;
  logic [mck_pkg::LenW-1:0]  left_q;
  logic [mck_pkg::ElemW-1:0] elems_q;
  logic                      out_valid_q;
  logic                      led_q;
  logic [mck_pkg::DurW-1:0]  dur_q;
  logic                      last_q;

  logic [mck_pkg::UnitW-1:0] unit;
  logic [mck_pkg::DurW-1:0]  u1, u2, u3, u4;
  logic                      slot_free;

  // Out-of-range unit values are pinned to the legal range.
  always_comb begin
    unit = dot_time_i;
    if (dot_time_i < mck_pkg::UnitMin) begin
      unit = mck_pkg::UnitMin;
    end else if (dot_time_i > mck_pkg::UnitMax) begin
      unit = mck_pkg::UnitMax;
    end
    u1 = mck_pkg::DurW'(unit);
    u2 = u1 << 1;
    u3 = u1 + u2;
    u4 = u1 << 2;
  end

  assign slot_free = !out_valid_q || pop_i;
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;
  assign empty_o   = !out_valid_q;
  assign led_on_o      = led_q;
  assign duration_ms_o = dur_q;
  assign last_o        = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= mck_pkg::JOB_SPACE;
      left_q      <= '0;
      elems_q     <= '0;
      led_q       <= 1'b0;
      dur_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            kind_q  <= job_i.kind;
            left_q  <= job_i.len;
            elems_q <= job_i.elems;
            state_q <= (job_i.kind == mck_pkg::JOB_SPACE || job_i.len == '0) ?
                       ST_CLOSE : ST_LIT;
          end
        end
        ST_LIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            led_q       <= 1'b1;
            dur_q       <= elems_q[mck_pkg::ElemW-1] ? u3 : u1;
            last_q      <= 1'b0;
            elems_q     <= elems_q << 1;
            left_q      <= left_q - 1'b1;
            state_q     <= ST_DARK;
          end
        end
        ST_DARK: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            led_q       <= 1'b0;
            dur_q       <= u1;
            last_q      <= 1'b0;
            state_q     <= (left_q == '0) ? ST_CLOSE : ST_LIT;
          end
        end
        ST_CLOSE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            led_q       <= 1'b0;
            dur_q       <= (kind_q == mck_pkg::JOB_SPACE) ? u4 : u2;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/morse_character_keyer.sv */
// Top level of the Morse character keyer: unit register, front end, job queue, sequencer.
//
// Push one ASCII character per item; lower case is folded to upper case. A letter or
// digit produces two intervals per dot or dash plus a closing gap, so up to eleven
// result items; a space produces one dark interval of four units; any other code
// produces nothing. The sequencer emits one interval per cycle while pop keeps up,
// and loads each character from the job queue in its idle state. The job queue
// (JobDepth entries) absorbs a burst of characters while the sequencer works; full
// rises only when it is full. The unit time is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, which the block itself does
// not enforce. Values below 1 are used as 1 and above 1000 as 1000.
module morse_character_keyer #(
  parameter int unsigned JobDepth = mck_pkg::JobDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mck_pkg::UnitW-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic [mck_pkg::CharW-1:0] char_code_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      led_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ms_o,
  output logic                      last_o
);

  logic [mck_pkg::UnitW-1:0] dot_time_q;
  logic                      job_valid;
  mck_pkg::job_t             job_in;
  mck_pkg::job_t             job_out;
  logic                      job_empty;
  logic                      job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_time_q <= mck_pkg::UnitReset;
    end else if (cfg_we_i) begin
      dot_time_q <= cfg_wdata_i;
    end
  end

  mck_front u_front (
    .char_code_i (char_code_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  mck_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push && job_valid),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_en_i   (job_pop),
    .empty_o   (job_empty),
    .rd_data_o (job_out)
  );

  mck_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dot_time_i    (dot_time_q),
    .job_empty_i   (job_empty),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .led_on_o      (led_on_o),
    .duration_ms_o (duration_ms_o),
    .last_o        (last_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Morse character keyer: stimulus, interval prediction, checks.
`timescale 1ns / 100ps

module testbench;
  localparam int unsigned CharW = mck_pkg::CharW;
  localparam int unsigned UnitW = mck_pkg::UnitW;
  localparam int unsigned DurW  = mck_pkg::DurW;

  localparam int UnitFloor    = 1;
  localparam int UnitCeiling  = 1000;
  localparam int DashUnits    = 3;
  localparam int CloseUnits   = 2;
  localparam int SpaceUnits   = 4;
  localparam int ResetUnit    = 200;
  localparam int SettleCycles = 30;
  localparam int DrainLimit   = 20000;
  localparam int PrintLimit   = 40;

  typedef struct packed {
    logic            led_on;
    logic [DurW-1:0] duration_ms;
    logic            last;
  } interval_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [UnitW-1:0] cfg_wdata_i = '0;
  logic             push        = 1'b0;
  logic             full;
  logic [CharW-1:0] char_code_i = '0;
  logic             empty;
  logic             pop         = 1'b0;
  logic             led_on_o;
  logic [DurW-1:0]  duration_ms_o;
  logic             last_o;

  interval_t        intervals_due[$];
  logic [UnitW-1:0] unit_setting = UnitW'(ResetUnit);
  bit               steady_flow  = 1'b0;
  int               mismatches   = 0;
  int               chars_sent   = 0;
  int               intervals_seen = 0;
  int               unit_writes  = 0;

  morse_character_keyer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .empty         (empty),
    .pop           (pop),
    .led_on_o      (led_on_o),
    .duration_ms_o (duration_ms_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string morse_of(input logic [CharW-1:0] up);
    case (up)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  task automatic add_interval(input logic led, input int dur, input logic fin);
    interval_t iv;
    iv.led_on      = led;
    iv.duration_ms = dur[DurW-1:0];
    iv.last        = fin;
    intervals_due.push_back(iv);
  endtask

  task automatic predict_intervals(input logic [CharW-1:0] code);
    logic [CharW-1:0] up;
    string            elems;
    int               unit;
    up = code;
    if (code >= "a" && code <= "z") up = code - 8'h20;
    unit = int'(unit_setting);
    if (unit < UnitFloor) unit = UnitFloor;
    if (unit > UnitCeiling) unit = UnitCeiling;
    if (up == " ") begin
      add_interval(1'b0, SpaceUnits * unit, 1'b1);
      return;
    end
    elems = morse_of(up);
    if (elems.len() == 0) return;
    for (int i = 0; i < elems.len(); i++) begin
      add_interval(1'b1, (elems[i] == "-") ? DashUnits * unit : unit, 1'b0);
      add_interval(1'b0, unit, 1'b0);
    end
    add_interval(1'b0, CloseUnits * unit, 1'b1);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] code);
    push        <= 1'b1;
    char_code_i <= code;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_intervals(code);
    chars_sent++;
    if (!steady_flow) idle_sender(gap_length());
  endtask

  // Hold the sender until every predicted interval is out, then let the block settle.
  task automatic drain();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (intervals_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (intervals_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted intervals never came out",
                                intervals_due.size()));
      intervals_due.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_unit(input logic [UnitW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    unit_setting = value;
    unit_writes++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  function automatic logic [CharW-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CharW'("A" + $urandom_range(0, 25));
    if (r < 60) return CharW'("a" + $urandom_range(0, 25));
    if (r < 75) return CharW'("0" + $urandom_range(0, 9));
    if (r < 85) return " ";
    return CharW'($urandom_range(0, 255));
  endfunction

  task automatic test_directed_codes();
    // Range edges of the letter and digit groups, case folding, and codes that key nothing.
    send_text("aZz09 5Q");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("@[`{/:");
  endtask

  task automatic test_unit_extremes();
    logic [UnitW-1:0] values[5];
    values = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd1001};
    foreach (values[i]) begin
      write_unit(values[i]);
      send_char((i % 2 == 0) ? "0" : "E");
      send_char((i % 2 == 0) ? " " : "T");
    end
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_unit(10'd1);
        1: write_unit(10'd1000);
        4: write_unit(10'd1023);
        5: write_unit(UnitW'($urandom_range(0, 1023)));
        default: write_unit(UnitW'($urandom_range(1, 1000)));
      endcase
      // One phase runs with no gaps on either side.
      steady_flow = (phase == 3);
      repeat (60) send_char(random_char());
    end
    steady_flow = 1'b0;
  endtask

  initial begin : pop_driver
    int n;
    @(posedge rst_ni);
    forever begin
      if (steady_flow) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 12);
        pop <= 1'b1;
        repeat (n) @(posedge clk_i);
        n = gap_length();
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : interval_checker
    interval_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        intervals_seen++;
        if (intervals_due.size() == 0) begin
          report_mismatch($sformatf("unexpected interval led=%0b dur=%0d last=%0b",
                                    led_on_o, duration_ms_o, last_o));
        end else begin
          want = intervals_due.pop_front();
          if (led_on_o !== want.led_on)
            report_mismatch($sformatf("led_on %0b, expected %0b", led_on_o, want.led_on));
          if (duration_ms_o !== want.duration_ms)
            report_mismatch($sformatf("duration_ms %0d, expected %0d",
                                      duration_ms_o, want.duration_ms));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_codes();
    test_unit_extremes();
    test_random_text();
    drain();
    $display("Keyed %0d characters under %0d unit settings; %0d intervals compared.",
             chars_sent, unit_writes, intervals_seen);
    $display("Covered letter and digit edges, case folding, spaces, ignored codes and clamps.");
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* morse_character_keyer.f */
rtl/mck_pkg.sv
rtl/mck_front.sv
rtl/mck_job_fifo.sv
rtl/mck_back.sv
rtl/morse_character_keyer.sv
test/testbench.sv
